// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is high.
`define FUD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FUD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/fud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fud_pkg
// Types, codes and helpers shared by the form body decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

   localparam int MAX_RESULTS         = 5;
   localparam int MAX_DECODED         = 4;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [1:0] KIND_NAME     = 2'd0;
   localparam logic [1:0] KIND_VALUE    = 2'd1;
   localparam logic [1:0] KIND_PAIR_END = 2'd2;
   localparam logic [1:0] KIND_BODY_END = 2'd3;

   localparam logic [1:0] CSR_PLUS_TO_SPACE   = 2'd0;
   localparam logic [1:0] CSR_DECIMAL_ONLY    = 2'd1;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_PERCENT,
      ESC_DIGIT
   } esc_phase_type;

   // All results caused by one request, oldest in slot 0.
   typedef struct packed {
      logic [2:0]                   count;
      logic [MAX_RESULTS-1:0][1:0]  kind;
      logic [MAX_RESULTS-1:0][7:0]  data;
   } bundle_type;

   function automatic logic digit_ok(input logic [7:0] b, input logic dec_only);
      logic dec;
      logic hex;
      dec = (b >= 8'h30) && (b <= 8'h39);
      hex = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
      return dec || (hex && !dec_only);
   endfunction

   // Valid only for accepted digits; letters carry a low nibble of 1..6.
   function automatic logic [3:0] digit_val(input logic [7:0] b);
      return b[6] ? (b[3:0] + 4'd9) : b[3:0];
   endfunction

endpackage

// File: rtl/core/form_urlencoded_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_urlencoded_decoder
// Streaming decoder for form bodies: raw bytes in, name/value bytes and
// pair/body end markers out.
//
// Requests: a raw byte with its last flag is taken when push is high and
// full is low. Results: while empty is low the oldest result sits on the
// rsp_ ports and leaves when pop is high. Configuration: csr_index and
// csr_data are written when valid is high; ready is always high.
// A request's results enter the queue in the cycle after it is taken. A
// request may be taken every cycle while full is low; each request's
// results (up to five) leave one per cycle while pop is high, so sustained
// rate is one request per cycle when each causes at most one result, and
// otherwise the result port, at one result per cycle, sets the pace.
// Requests that cause no result only update the decoder state.
// A stalled receiver fills the bundle queue (QUEUE_DEPTH requests); full
// then holds the sender off until results are popped.
// Reset empties the queue, clears the pair state and restores the
// registers: plus to space on, decimal-only escapes off.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder
   import fud_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       valid,
   output logic       ready,
   input  logic [1:0] csr_index,
   input  logic       csr_data
);

   bundle_type front_bundle;
   bundle_type head_bundle;
   logic       take;
   logic       q_empty;
   logic       q_pop;

   assign ready = 1'b1;
   assign take  = push && !full;

   fud_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_take   (take),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .csr_write (valid && ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bundle    (front_bundle)
   );

   fud_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (take && (front_bundle.count != 3'd0)),
      .wr_bundle (front_bundle),
      .rd_en     (q_pop),
      .rd_bundle (head_bundle),
      .q_empty   (q_empty),
      .q_full    (full)
   );

   fud_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_bundle),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .out_kind (rsp_out_kind),
      .out_byte (rsp_out_byte),
      .out_last (rsp_out_last)
   );

endmodule

// File: rtl/core/fud_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fud_front
// Takes raw bytes, tracks escape and pair state, and builds the bundle of
// results that each request causes. Holds the configuration registers.
// ----------------------------------------------------------------------------
module fud_front
   import fud_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_take,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic       csr_data,
   output bundle_type bundle
);

   esc_phase_type phase_ff, phase_in, mid_phase;
   logic [7:0]    held_ff, held_in;
   logic          value_ff, value_in;
   logic          open_ff, open_in;
   logic          plus_ff, plus_in;
   logic          dec_ff, dec_in;

   logic          is_amp;
   logic          b_ok;
   logic          h_ok;
   logic          enter_digit;

   logic [MAX_DECODED-1:0][7:0] cand;
   logic [2:0]                  k;
   logic [2:0]                  n;
   logic                        iv;
   logic                        do_plain;

   assign is_amp      = (in_byte == CHAR_AMP);
   assign b_ok        = digit_ok(in_byte, dec_ff);
   assign h_ok        = digit_ok(held_ff, dec_ff);
   assign enter_digit = !is_amp && (phase_ff == ESC_PERCENT) && b_ok;

   always_comb begin
      if (is_amp) begin
         mid_phase = ESC_NONE;
      end else begin
         case (phase_ff)
            ESC_PERCENT: begin
               if (b_ok) mid_phase = ESC_DIGIT;
               else      mid_phase = (in_byte == CHAR_PERCENT) ? ESC_PERCENT : ESC_NONE;
            end
            ESC_DIGIT: begin
               if (b_ok && h_ok) mid_phase = ESC_NONE;
               else mid_phase = (in_byte == CHAR_PERCENT) ? ESC_PERCENT : ESC_NONE;
            end
            default: begin
               mid_phase = (in_byte == CHAR_PERCENT) ? ESC_PERCENT : ESC_NONE;
            end
         endcase
      end
      phase_in = in_last ? ESC_NONE : mid_phase;
   end

   always_comb begin
      cand     = '0;
      k        = 3'd0;
      do_plain = 1'b0;
      if (is_amp) begin
         if (phase_ff != ESC_NONE) begin
            cand[k[1:0]] = CHAR_PERCENT;
            k = k + 3'd1;
         end
         if (phase_ff == ESC_DIGIT) begin
            cand[k[1:0]] = held_ff;
            k = k + 3'd1;
         end
      end else begin
         case (phase_ff)
            ESC_PERCENT: begin
               if (!b_ok) begin
                  cand[k[1:0]] = CHAR_PERCENT;
                  k = k + 3'd1;
                  do_plain = 1'b1;
               end
            end
            ESC_DIGIT: begin
               if (b_ok && h_ok) begin
                  cand[k[1:0]] = {digit_val(held_ff), digit_val(in_byte)};
                  k = k + 3'd1;
               end else begin
                  cand[k[1:0]] = CHAR_PERCENT;
                  k = k + 3'd1;
                  cand[k[1:0]] = held_ff;
                  k = k + 3'd1;
                  do_plain = 1'b1;
               end
            end
            default: do_plain = 1'b1;
         endcase
         if (do_plain && (in_byte != CHAR_PERCENT)) begin
            cand[k[1:0]] = (plus_ff && (in_byte == CHAR_PLUS)) ? CHAR_SPACE : in_byte;
            k = k + 3'd1;
         end
         if (in_last && (mid_phase != ESC_NONE)) begin
            cand[k[1:0]] = CHAR_PERCENT;
            k = k + 3'd1;
         end
         if (in_last && (mid_phase == ESC_DIGIT)) begin
            cand[k[1:0]] = in_byte;
            k = k + 3'd1;
         end
      end
   end

   always_comb begin
      bundle = '0;
      iv     = value_ff;
      n      = 3'd0;
      for (int i = 0; i < MAX_DECODED; i++) begin
         if (3'(i) < k) begin
            if (!iv && (cand[i] == CHAR_EQUALS)) begin
               iv = 1'b1;
            end else begin
               bundle.kind[n] = iv ? KIND_VALUE : KIND_NAME;
               bundle.data[n] = cand[i];
               n = n + 3'd1;
            end
         end
      end
      if (is_amp ? open_ff : in_last) begin
         bundle.kind[n] = KIND_PAIR_END;
         n = n + 3'd1;
      end
      if (in_last) begin
         bundle.kind[n] = KIND_BODY_END;
         n = n + 3'd1;
      end
      bundle.count = n;
   end

   assign value_in = (is_amp || in_last) ? 1'b0 : iv;
   assign open_in  = !(is_amp || in_last);
   assign held_in  = enter_digit ? in_byte : held_ff;
   assign plus_in  = (csr_write && (csr_index == CSR_PLUS_TO_SPACE)) ? csr_data : plus_ff;
   assign dec_in   = (csr_write && (csr_index == CSR_DECIMAL_ONLY)) ? csr_data : dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ESC_NONE;
         value_ff <= 1'b0;
         open_ff  <= 1'b0;
         plus_ff  <= 1'b1;
         dec_ff   <= 1'b0;
      end else begin
         plus_ff <= plus_in;
         dec_ff  <= dec_in;
         if (in_take) begin
            phase_ff <= phase_in;
            value_ff <= value_in;
            open_ff  <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         held_ff <= held_in;
      end
   end

endmodule

// File: rtl/core/fud_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fud_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module fud_queue
   import fud_pkg::*;
#(
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  bundle_type wr_bundle,
   input  logic       rd_en,
   output bundle_type rd_bundle,
   output logic       q_empty,
   output logic       q_full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(DEPTH);

   bundle_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]       level_ff, level_in;
   logic                   do_wr;
   logic                   do_rd;

   assign q_empty   = (level_ff == '0);
   assign q_full    = (level_ff == LVL_MAX);
   assign do_wr     = wr_en && !q_full;
   assign do_rd     = rd_en && !q_empty;
   assign rd_bundle = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = !do_wr ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = !do_rd ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + PTR_W'(1);

   always_comb begin
      level_in = level_ff;
      if (do_wr && !do_rd) level_in = level_ff + LVL_W'(1);
      if (do_rd && !do_wr) level_in = level_ff - LVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_bundle;
      end
   end

endmodule

// File: rtl/core/fud_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fud_back
// Walks the head bundle one result per pop and releases it after its last.
// ----------------------------------------------------------------------------
module fud_back
   import fud_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       q_empty,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output logic [1:0] out_kind,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [2:0] idx_ff, idx_in;
   logic       take;

   assign empty    = q_empty;
   assign take     = pop && !q_empty;
   assign out_kind = head.kind[idx_ff];
   assign out_byte = head.data[idx_ff];
   assign out_last = (idx_ff == (head.count - 3'd1));
   assign q_pop    = take && out_last;
   assign idx_in   = !take ? idx_ff : (out_last ? 3'd0 : idx_ff + 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: rtl/core/fud_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fud_checker
// Port-level checks on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fud_checker
   import fud_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   `FUD_ASSERT(a_rsp_hold, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_out_kind) && $stable(rsp_out_byte) && $stable(rsp_out_last)), "stalled response changed")
   `FUD_ASSERT(a_marker_zero, clock, reset, (!empty && rsp_out_kind[1]) |-> (rsp_out_byte == 8'd0), "marker carries nonzero byte")
   `FUD_ASSERT(a_body_end_last, clock, reset, (!empty && (rsp_out_kind == KIND_BODY_END)) |-> rsp_out_last, "body end not last of request")
   `FUD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> empty, "responses present after reset")

endmodule

bind form_urlencoded_decoder fud_checker u_fud_checker (
   .clock        (clock),
   .reset        (reset),
   .empty        (empty),
   .pop          (pop),
   .rsp_out_kind (rsp_out_kind),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

// File: tb/sv/tb_form_urlencoded_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_form_urlencoded_decoder
// Self-checking bench for the form body decoder. A short table of directed
// requests covers escapes, plus handling, pair and body ends and both escape
// modes. Random bodies follow: mostly well-formed name=value pairs, plus
// noise. A predictor in the bench tracks the pair state and both registers,
// and every popped result is compared field by field with the oldest
// expected one. Sender and receiver idle at random in three mixes, and the
// receiver stalls once for a long stretch so the block fills up.
// ----------------------------------------------------------------------------
module tb_form_urlencoded_decoder;
   import fud_pkg::*;

   localparam int RX_STALL_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int ITEMS_PER_SET   = 24;

   typedef enum logic {ROW_BYTE, ROW_REGS} row_op_type;
   typedef enum logic [1:0] {EXP_PREDICTED, EXP_ONE, EXP_NONE} exp_mode_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } token_type;

   typedef struct packed {
      row_op_type   op;
      logic [7:0]   data;
      logic         last;
      exp_mode_type mode;
      logic [1:0]   kind;
      logic [7:0]   exp_data;
      logic         plus;
      logic         dec;
   } row_type;

   localparam int N_ROWS = 27;
   localparam row_type DIRECTED [N_ROWS] = '{
      '{ROW_BYTE, "a",          1'b0, EXP_ONE,       KIND_NAME,     "a",         1'b0, 1'b0},
      '{ROW_BYTE, CHAR_EQUALS,  1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PLUS,    1'b0, EXP_ONE,       KIND_VALUE,    CHAR_SPACE,  1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PERCENT, 1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "0",          1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "0",          1'b0, EXP_ONE,       KIND_VALUE,    8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_EQUALS,  1'b0, EXP_ONE,       KIND_VALUE,    CHAR_EQUALS, 1'b0, 1'b0},
      '{ROW_BYTE, CHAR_AMP,     1'b0, EXP_ONE,       KIND_PAIR_END, 8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_AMP,     1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, 8'hFF,        1'b0, EXP_ONE,       KIND_NAME,     8'hFF,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PERCENT, 1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "g",          1'b0, EXP_PREDICTED, KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PERCENT, 1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "3",          1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "d",          1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PERCENT, 1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_AMP,     1'b0, EXP_PREDICTED, KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_REGS, 8'h00,        1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b1},
      '{ROW_BYTE, CHAR_PLUS,    1'b0, EXP_ONE,       KIND_NAME,     CHAR_PLUS,   1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PERCENT, 1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "a",          1'b0, EXP_PREDICTED, KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_PERCENT, 1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "3",          1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, "D",          1'b1, EXP_PREDICTED, KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_REGS, 8'h00,        1'b0, EXP_NONE,      KIND_NAME,     8'h00,       1'b1, 1'b0},
      '{ROW_BYTE, 8'h00,        1'b1, EXP_PREDICTED, KIND_NAME,     8'h00,       1'b0, 1'b0},
      '{ROW_BYTE, CHAR_AMP,     1'b1, EXP_ONE,       KIND_BODY_END, 8'h00,       1'b0, 1'b0}
   };

   logic       clock;
   logic       reset        = 1'b1;
   logic       push         = 1'b0;
   logic       full;
   logic [7:0] req_in_byte  = 8'h00;
   logic       req_in_last  = 1'b0;
   logic       empty;
   logic       pop          = 1'b0;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       valid        = 1'b0;
   logic       ready;
   logic [1:0] csr_index    = CSR_PLUS_TO_SPACE;
   logic       csr_data     = 1'b0;

   // expectation source of the request on the ports
   exp_mode_type req_mode   = EXP_PREDICTED;
   logic [1:0]   req_kind   = KIND_NAME;
   logic [7:0]   req_data   = 8'h00;

   // decoder mirror
   esc_phase_type esc_state    = ESC_NONE;
   logic [7:0]    held_char    = 8'h00;
   logic          value_part   = 1'b0;
   logic          pair_started = 1'b0;
   logic          plus_cfg     = 1'b1;
   logic          dec_cfg      = 1'b0;

   token_type step_tokens[$];
   token_type tokens_due[$];

   int  tx_idle_pct  = 21;
   int  rx_idle_pct  = 88;
   bit  rx_stall_req = 1'b0;
   int  n_sent       = 0;
   int  n_taken      = 0;
   int  n_checked    = 0;
   int  n_writes     = 0;
   int  n_errors     = 0;

   form_urlencoded_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .valid        (valid),
      .ready        (ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout at %0t with %0d results outstanding", $time, tokens_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ---- predictor ----

   function automatic int digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (dec_cfg) return -1;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   function automatic void add_token(input logic [1:0] k, input logic [7:0] d);
      step_tokens.push_back('{k, d, 1'b0});
   endfunction

   function automatic void add_decoded(input logic [7:0] c);
      if (!value_part && c == CHAR_EQUALS) value_part = 1'b1;
      else add_token(value_part ? KIND_VALUE : KIND_NAME, c);
   endfunction

   function automatic void flush_escape();
      if (esc_state != ESC_NONE) add_decoded(CHAR_PERCENT);
      if (esc_state == ESC_DIGIT) add_decoded(held_char);
      esc_state = ESC_NONE;
      held_char = 8'h00;
   endfunction

   function automatic void plain_char(input logic [7:0] c);
      if (c == CHAR_PERCENT) esc_state = ESC_PERCENT;
      else if (c == CHAR_PLUS && plus_cfg) add_decoded(CHAR_SPACE);
      else add_decoded(c);
   endfunction

   function automatic void close_pair();
      flush_escape();
      if (pair_started) add_token(KIND_PAIR_END, 8'h00);
      value_part   = 1'b0;
      pair_started = 1'b0;
   endfunction

   function automatic void decode_request(input logic [7:0] c, input logic lst);
      int lo;
      int hi;
      step_tokens.delete();
      if (c == CHAR_AMP) begin
         close_pair();
      end else begin
         pair_started = 1'b1;
         case (esc_state)
            ESC_NONE: begin
               plain_char(c);
            end
            ESC_PERCENT: begin
               if (digit_of(c) >= 0) begin
                  held_char = c;
                  esc_state = ESC_DIGIT;
               end else begin
                  flush_escape();
                  plain_char(c);
               end
            end
            default: begin
               lo = digit_of(c);
               hi = digit_of(held_char);
               if (lo >= 0 && hi >= 0) begin
                  esc_state = ESC_NONE;
                  held_char = 8'h00;
                  add_decoded(8'((hi << 4) | lo));
               end else begin
                  flush_escape();
                  plain_char(c);
               end
            end
         endcase
      end
      if (lst) begin
         close_pair();
         add_token(KIND_BODY_END, 8'h00);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
   endfunction

   // ---- monitor and checker ----

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         plus_cfg     = 1'b1;
         dec_cfg      = 1'b0;
         esc_state    = ESC_NONE;
         held_char    = 8'h00;
         value_part   = 1'b0;
         pair_started = 1'b0;
      end else begin
         if (pop && !empty) begin
            if (tokens_due.size() == 0) begin
               n_errors++;
               $display("%0t: unexpected result kind %0d byte %02h last %0b",
                        $time, rsp_out_kind, rsp_out_byte, rsp_out_last);
            end else begin
               want = tokens_due.pop_front();
               n_checked++;
               if (rsp_out_kind !== want.kind) begin
                  n_errors++;
                  $display("%0t: kind mismatch, expected %0d, actual %0d",
                           $time, want.kind, rsp_out_kind);
               end
               if (rsp_out_byte !== want.data) begin
                  n_errors++;
                  $display("%0t: byte mismatch, expected %02h, actual %02h",
                           $time, want.data, rsp_out_byte);
               end
               if (rsp_out_last !== want.last) begin
                  n_errors++;
                  $display("%0t: last mismatch, expected %0b, actual %0b",
                           $time, want.last, rsp_out_last);
               end
            end
         end
         if (valid && ready) begin
            n_writes++;
            case (csr_index)
               CSR_PLUS_TO_SPACE: plus_cfg = csr_data;
               CSR_DECIMAL_ONLY:  dec_cfg  = csr_data;
               default: ;
            endcase
         end
         if (push && !full) begin
            n_taken++;
            decode_request(req_in_byte, req_in_last);
            case (req_mode)
               EXP_PREDICTED: foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
               EXP_ONE:       tokens_due.push_back('{req_kind, req_data, 1'b1});
               default: ;
            endcase
         end
      end
   end

   // ---- receiver ----

   initial begin
      forever begin
         @(posedge clock);
         if (rx_stall_req) begin
            rx_stall_req = 1'b0;
            pop <= 1'b0;
            repeat (RX_STALL_CYCLES) @(posedge clock);
         end
         pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // ---- sender ----

   task automatic send_byte(input logic [7:0] b, input logic lst, input exp_mode_type mode,
                            input logic [1:0] k, input logic [7:0] d);
      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      push        <= 1'b1;
      req_in_byte <= b;
      req_in_last <= lst;
      req_mode    <= mode;
      req_kind    <= k;
      req_data    <= d;
      @(posedge clock);
      while (full) @(posedge clock);
      n_sent++;
   endtask

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic plus, input logic dec);
      valid     <= 1'b1;
      csr_index <= CSR_PLUS_TO_SPACE;
      csr_data  <= plus;
      @(posedge clock);
      while (!ready) @(posedge clock);
      csr_index <= CSR_DECIMAL_ONLY;
      csr_data  <= dec;
      @(posedge clock);
      while (!ready) @(posedge clock);
      valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_digit();
      int v;
      v = $urandom_range(0, dec_cfg ? 11 : 21);
      if (v < 10) return 8'("0" + v);
      if (v < 16) return 8'("a" + v - 10);
      return 8'("A" + v - 16);
   endfunction

   function automatic void add_piece(ref logic [7:0] q[$]);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         q.push_back(8'($urandom_range(8'h30, 8'h7A)));
      end else if (r < 55) begin
         q.push_back(CHAR_PLUS);
      end else if (r < 75) begin
         q.push_back(CHAR_PERCENT);
         q.push_back(pick_digit());
         q.push_back(pick_digit());
      end else if (r < 85) begin
         q.push_back(CHAR_PERCENT);
         if (r < 80) q.push_back(pick_digit());
         q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 92) begin
         q.push_back(CHAR_EQUALS);
      end else begin
         q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_body();
      logic [7:0] body[$];
      int         pairs;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) body.push_back(8'($urandom_range(0, 255)));
      end else begin
         pairs = $urandom_range(1, 4);
         for (int p = 0; p < pairs; p++) begin
            if ($urandom_range(0, 9) == 0) body.push_back(CHAR_AMP);
            repeat ($urandom_range(0, 4)) add_piece(body);
            if ($urandom_range(0, 99) < 85) body.push_back(CHAR_EQUALS);
            repeat ($urandom_range(0, 5)) add_piece(body);
            if (p < pairs - 1 || $urandom_range(0, 9) == 0) body.push_back(CHAR_AMP);
         end
      end
      if (body.size() == 0) body.push_back("x");
      foreach (body[i]) begin
         send_byte(body[i], i == body.size() - 1, EXP_PREDICTED, KIND_NAME, 8'h00);
      end
   endtask

   // ---- main sequence ----

   initial begin
      int goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_ROWS; i++) begin
         if (DIRECTED[i].op == ROW_REGS) begin
            drain();
            write_regs(DIRECTED[i].plus, DIRECTED[i].dec);
         end else begin
            send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].mode,
                      DIRECTED[i].kind, DIRECTED[i].exp_data);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 88 : 0;
         rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 21 : 0;
         for (int s = 0; s < 4; s++) begin
            drain();
            write_regs(s[0], s[1]);
            // long receiver stall while requests keep coming
            if (ph == 2 && s == 1) rx_stall_req = 1'b1;
            goal = n_sent + ITEMS_PER_SET;
            while (n_sent < goal) send_body();
         end
      end

      drain();
      repeat (20) @(posedge clock);

      $display("Run covered %0d requests, %0d results and %0d register writes,",
               n_taken, n_checked, n_writes);
      $display("all four register settings, three idle mixes and a long receiver stall.");
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fud_pkg.sv
rtl/core/fud_front.sv
rtl/core/fud_queue.sv
rtl/core/fud_back.sv
rtl/core/form_urlencoded_decoder.sv
rtl/core/fud_checker.sv
tb/sv/tb_form_urlencoded_decoder.sv
